### src/pooled_linked_list_manager_macros.svh
// Assertion macros shared by the pooled linked-list manager RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef POOLED_LINKED_LIST_MANAGER_MACROS_SVH
`define POOLED_LINKED_LIST_MANAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLLM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLLM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pllm_pkg.sv
// Package of the pooled linked-list manager: field widths, stream packing,
// opcodes and the result record. No dependencies.
package pllm_pkg;

	localparam int LINK_W = 6;
	localparam logic [LINK_W-1:0] NULL_LINK = '1;

	localparam int OPCODE_W = 3;
	localparam int LIST_ID_W = 2;
	localparam int ITEM_W = 32;
	localparam int COUNT_W = 5;

	localparam int OPCODE_LSB = 0;
	localparam int LIST_ID_LSB = OPCODE_LSB + OPCODE_W;
	localparam int ITEM_LSB = LIST_ID_LSB + LIST_ID_W;

	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 40;

	localparam int DEF_POOL_NODES = 20;
	localparam int DEF_NUM_LISTS = 4;
	localparam int DEF_WORD_BITS = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND = 3'd0,
		OP_FIRST = 3'd1,
		OP_NEXT = 3'd2,
		OP_SIZE = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	typedef struct packed {
		logic status;
		logic [ITEM_W-1:0] data;
		logic valid;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

### src/pllm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-during-write to the same address returns the old contents. No dependencies.
module pllm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/pooled_linked_list_manager.sv
// Top level of the pooled linked-list manager: list registers, free map and sequencer.
// Depends on pllm_pkg, pllm_ram and pooled_linked_list_manager_macros.svh.
//
// Channel  Dir  Beat contents (lowest bit first)
// s_*      in   tdata: opcode[2:0], list_id[4:3], item_data[36:5], zero pad
// m_*      out  tdata: status[0], out_data[32:1], list_count[37:33], zero pad;
//               tuser: data_valid[0]
//
// Size and failing ops go from dispatch straight to the result; first reads the head's word;
// next reads a link, then its word unless it runs off the tail; append and clear walk the list
// with one link RAM read per node. A beat waits in S_DONE while the previous result waits.
// Reset is asynchronous and marks every node free and every list empty at once.
// A result waits in the output register; the next beat is accepted meanwhile
// and its result is held back until the waiting one is taken.
`include "pooled_linked_list_manager_macros.svh"

module pooled_linked_list_manager #(
	parameter int POOL_NODES = pllm_pkg::DEF_POOL_NODES,
	parameter int NUM_LISTS = pllm_pkg::DEF_NUM_LISTS,
	parameter int WORD_BITS = pllm_pkg::DEF_WORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// opcode, list_id, item_data
	input  logic [pllm_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status, out_data, list_count
	output logic [pllm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// data_valid
	output logic [0:0]                         m_tuser
);

	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int SIZE_W = $clog2(POOL_NODES + 1);
	localparam int LSEL_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int TOTAL_W = SIZE_W + 4;
	localparam int LW = pllm_pkg::LINK_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_APP_WALK,
		S_NEXT_LINK,
		S_READ_WORD,
		S_CLR_WALK,
		S_DONE
	} state_t;

	state_t state_q;
	logic [pllm_pkg::OPCODE_W-1:0] op_q;
	logic [LSEL_W-1:0] lsel_q;
	logic id_ok_q;
	logic [WORD_BITS-1:0] word_q;

	logic [LW-1:0] head_q [NUM_LISTS];
	logic [LW-1:0] cursor_q [NUM_LISTS];
	logic [SIZE_W-1:0] size_q [NUM_LISTS];
	logic [POOL_NODES-1:0] free_q;
	logic [POOL_NODES-1:0] link_vld_q;

	logic [LW-1:0] t_q;
	logic [LW-1:0] fresh_q;
	logic [SIZE_W-1:0] steps_q;
	logic vld_rd_q;
	pllm_pkg::result_t res_q;
	pllm_pkg::result_t out_q;
	logic out_valid_q;

	logic [LW-1:0] h, cur_raw, cur_sel, lnk_rd, fresh_idx;
	logic h_ok, cur_ok, lnk_ok, pool_full, walk_more, clr_more;
	logic [SIZE_W-1:0] sz, sz_inc;
	logic [POOL_NODES-1:0] iso;
	logic [TOTAL_W-1:0] size_total;

	logic link_we;
	logic [IDX_W-1:0] link_waddr, link_raddr;
	logic [LW-1:0] link_wdata, link_rdata;
	logic word_we;
	logic [IDX_W-1:0] word_waddr, word_raddr;
	logic [WORD_BITS-1:0] word_rdata;

	pllm_ram #(
		.WIDTH(LW),
		.DEPTH(POOL_NODES)
	) u_link_ram (
		.clk(clk),
		.we(link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	pllm_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(POOL_NODES)
	) u_word_ram (
		.clk(clk),
		.we(word_we),
		.waddr(word_waddr),
		.wdata(word_q),
		.raddr(word_raddr),
		.rdata(word_rdata)
	);

	always_comb begin
		h = id_ok_q ? head_q[lsel_q] : pllm_pkg::NULL_LINK;
		cur_raw = id_ok_q ? cursor_q[lsel_q] : pllm_pkg::NULL_LINK;
		sz = id_ok_q ? size_q[lsel_q] : '0;
		sz_inc = SIZE_W'(sz + 1'b1);
		h_ok = int'(h) < POOL_NODES;
		cur_ok = int'(cur_raw) < POOL_NODES;
		cur_sel = cur_ok ? cur_raw : h;
		lnk_rd = vld_rd_q ? link_rdata : pllm_pkg::NULL_LINK;
		lnk_ok = int'(lnk_rd) < POOL_NODES;
		walk_more = (int'(steps_q) < POOL_NODES) && lnk_ok;
		clr_more = (int'(steps_q) + 1 < POOL_NODES) && lnk_ok;
		pool_full = (free_q == '0);
	end

	// Lowest free node: isolate the lowest set bit, then encode the one-hot word.
	always_comb begin
		iso = free_q & (~free_q + POOL_NODES'(1));
		fresh_idx = '0;
		for (int i = 0; i < POOL_NODES; i++) begin
			for (int b = 0; b < LW; b++) begin
				if (((i >> b) & 1) == 1) begin
					fresh_idx[b] = fresh_idx[b] | iso[i];
				end
			end
		end
	end

	always_comb begin
		size_total = '0;
		for (int l = 0; l < NUM_LISTS; l++) begin
			size_total = size_total + TOTAL_W'(size_q[l]);
		end
	end

	always_comb begin
		link_we = 1'b0;
		link_waddr = '0;
		link_wdata = pllm_pkg::NULL_LINK;
		link_raddr = '0;
		word_we = 1'b0;
		word_waddr = '0;
		word_raddr = '0;
		unique case (state_q)
			S_DISPATCH: begin
				if (id_ok_q) begin
					unique case (op_q)
						pllm_pkg::OP_APPEND: begin
							if (!pool_full) begin
								word_we = 1'b1;
								word_waddr = fresh_idx[IDX_W-1:0];
								link_we = 1'b1;
								link_waddr = fresh_idx[IDX_W-1:0];
								if (h_ok) begin
									link_raddr = h[IDX_W-1:0];
								end
							end
						end
						pllm_pkg::OP_FIRST: begin
							if (h_ok) begin
								word_raddr = h[IDX_W-1:0];
							end
						end
						pllm_pkg::OP_NEXT: begin
							if (h_ok) begin
								link_raddr = cur_sel[IDX_W-1:0];
							end
						end
						pllm_pkg::OP_CLEAR: begin
							if (h_ok) begin
								link_raddr = h[IDX_W-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_APP_WALK: begin
				if (walk_more) begin
					link_raddr = lnk_rd[IDX_W-1:0];
				end else begin
					link_we = 1'b1;
					link_waddr = t_q[IDX_W-1:0];
					link_wdata = fresh_q;
				end
			end
			S_NEXT_LINK: begin
				if (lnk_ok) begin
					word_raddr = lnk_rd[IDX_W-1:0];
				end
			end
			S_CLR_WALK: begin
				link_we = 1'b1;
				link_waddr = t_q[IDX_W-1:0];
				if (clr_more) begin
					link_raddr = lnk_rd[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			free_q <= '1;
			link_vld_q <= '0;
			vld_rd_q <= 1'b0;
			id_ok_q <= 1'b0;
			for (int l = 0; l < NUM_LISTS; l++) begin
				head_q[l] <= pllm_pkg::NULL_LINK;
				cursor_q[l] <= pllm_pkg::NULL_LINK;
				size_q[l] <= '0;
			end
		end else begin
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (link_we) begin
				link_vld_q[link_waddr] <= 1'b1;
			end
			vld_rd_q <= link_vld_q[link_raddr];
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tdata[pllm_pkg::OPCODE_LSB +: pllm_pkg::OPCODE_W];
						lsel_q <= LSEL_W'(s_tdata[pllm_pkg::LIST_ID_LSB +: pllm_pkg::LIST_ID_W]);
						id_ok_q <= int'(s_tdata[pllm_pkg::LIST_ID_LSB +: pllm_pkg::LIST_ID_W])
							< NUM_LISTS;
						word_q <= WORD_BITS'(s_tdata[pllm_pkg::ITEM_LSB +: pllm_pkg::ITEM_W]);
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_q.status <= 1'b1;
					res_q.data <= '0;
					res_q.valid <= 1'b0;
					res_q.count <= pllm_pkg::COUNT_W'(sz);
					state_q <= S_DONE;
					if (id_ok_q) begin
						unique case (op_q)
							pllm_pkg::OP_APPEND: begin
								if (!pool_full) begin
									free_q[fresh_idx[IDX_W-1:0]] <= 1'b0;
									fresh_q <= fresh_idx;
									if (h_ok) begin
										t_q <= h;
										steps_q <= '0;
										state_q <= S_APP_WALK;
									end else begin
										head_q[lsel_q] <= fresh_idx;
										size_q[lsel_q] <= sz_inc;
										res_q.status <= 1'b0;
										res_q.count <= pllm_pkg::COUNT_W'(sz_inc);
									end
								end
							end
							pllm_pkg::OP_FIRST: begin
								if (h_ok) begin
									cursor_q[lsel_q] <= h;
									state_q <= S_READ_WORD;
								end
							end
							pllm_pkg::OP_NEXT: begin
								if (h_ok) begin
									state_q <= S_NEXT_LINK;
								end
							end
							pllm_pkg::OP_SIZE: begin
								res_q.status <= 1'b0;
							end
							pllm_pkg::OP_CLEAR: begin
								head_q[lsel_q] <= pllm_pkg::NULL_LINK;
								cursor_q[lsel_q] <= pllm_pkg::NULL_LINK;
								size_q[lsel_q] <= '0;
								res_q.status <= 1'b0;
								res_q.count <= '0;
								if (h_ok) begin
									t_q <= h;
									steps_q <= '0;
									state_q <= S_CLR_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_APP_WALK: begin
					if (walk_more) begin
						t_q <= lnk_rd;
						steps_q <= SIZE_W'(steps_q + 1'b1);
					end else begin
						size_q[lsel_q] <= sz_inc;
						res_q.status <= 1'b0;
						res_q.count <= pllm_pkg::COUNT_W'(sz_inc);
						state_q <= S_DONE;
					end
				end
				S_NEXT_LINK: begin
					if (lnk_ok) begin
						cursor_q[lsel_q] <= lnk_rd;
						state_q <= S_READ_WORD;
					end else begin
						cursor_q[lsel_q] <= pllm_pkg::NULL_LINK;
						state_q <= S_DONE;
					end
				end
				S_READ_WORD: begin
					res_q.status <= 1'b0;
					res_q.data <= pllm_pkg::ITEM_W'(word_rdata);
					res_q.valid <= 1'b1;
					state_q <= S_DONE;
				end
				S_CLR_WALK: begin
					free_q[t_q[IDX_W-1:0]] <= 1'b1;
					if (clr_more) begin
						t_q <= lnk_rd;
						steps_q <= SIZE_W'(steps_q + 1'b1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(pllm_pkg::OUT_TDATA_W - pllm_pkg::COUNT_W - pllm_pkg::ITEM_W - 1){1'b0}},
		out_q.count, out_q.data, out_q.status};
	assign m_tuser = out_q.valid;

	`PLLM_ASSERT_NXT(a_one_beat_at_a_time, s_tvalid && s_tready, !s_tready, "second beat accepted during an operation")
	`PLLM_ASSERT_IMP(a_pool_conserved, state_q == S_IDLE, (TOTAL_W'($countones(free_q)) + size_total) == TOTAL_W'(POOL_NODES), "free nodes and list sizes do not add up to the pool")
	`PLLM_ASSERT_IMP(a_data_means_ok, m_tvalid && m_tuser[0], !m_tdata[0], "element returned with a failing status")
	`PLLM_ASSERT_IMP(a_head_matches_size, (state_q == S_DISPATCH) && id_ok_q, h_ok == (sz != '0), "list head and list size disagree")

endmodule

### tb/pooled_linked_list_manager_test.sv
// Self-checking testbench for pooled_linked_list_manager: directed and random list traffic
// on the stream ports, checked beat by beat against a behavioral model of the node pool.
// Depends on pllm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module pooled_linked_list_manager_test;

	localparam int POOL = pllm_pkg::DEF_POOL_NODES;
	localparam int LISTS = pllm_pkg::DEF_NUM_LISTS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_STALL = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [pllm_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [pllm_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	pooled_linked_list_manager i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	logic [pllm_pkg::ITEM_W-1:0] pool_word [POOL];
	logic [pllm_pkg::LINK_W-1:0] pool_next [POOL];
	bit pool_free [POOL];
	logic [pllm_pkg::LINK_W-1:0] list_first [LISTS];
	logic [pllm_pkg::LINK_W-1:0] list_pos [LISTS];
	logic [pllm_pkg::COUNT_W-1:0] list_len [LISTS];

	pllm_pkg::result_t list_op_replies [$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_gen = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int mismatches = 0;
	int beats_sent = 0;
	int replies_checked = 0;
	int pool_full_hits = 0;
	int words_returned = 0;
	int cycle_count = 0;

	function automatic bit link_ok(input logic [pllm_pkg::LINK_W-1:0] lnk);
		return lnk < POOL;
	endfunction

	function automatic pllm_pkg::result_t predict_list_op(
			input logic [pllm_pkg::OPCODE_W-1:0] op,
			input logic [pllm_pkg::LIST_ID_W-1:0] lid,
			input logic [pllm_pkg::ITEM_W-1:0] word);
		pllm_pkg::result_t res;
		logic [pllm_pkg::LINK_W-1:0] h;
		logic [pllm_pkg::LINK_W-1:0] t;
		logic [pllm_pkg::LINK_W-1:0] nx;
		int fresh;
		res = '0;
		res.status = 1'b1;
		h = list_first[lid];
		case (op)
			pllm_pkg::OP_APPEND: begin
				fresh = -1;
				for (int i = 0; i < POOL; i++)
					if (pool_free[i] && fresh < 0)
						fresh = i;
				if (fresh >= 0) begin
					pool_free[fresh] = 1'b0;
					pool_word[fresh] = word;
					pool_next[fresh] = pllm_pkg::NULL_LINK;
					if (!link_ok(h)) begin
						list_first[lid] = pllm_pkg::LINK_W'(fresh);
					end else begin
						t = h;
						for (int i = 0; i < POOL && link_ok(pool_next[t]); i++)
							t = pool_next[t];
						pool_next[t] = pllm_pkg::LINK_W'(fresh);
					end
					list_len[lid] = list_len[lid] + 1'b1;
					res.status = 1'b0;
				end else begin
					pool_full_hits++;
				end
			end
			pllm_pkg::OP_FIRST: begin
				if (link_ok(h)) begin
					list_pos[lid] = h;
					res.data = pool_word[h];
					res.valid = 1'b1;
					res.status = 1'b0;
				end
			end
			pllm_pkg::OP_NEXT: begin
				if (!link_ok(list_pos[lid]))
					list_pos[lid] = h;
				if (link_ok(h) && link_ok(list_pos[lid])) begin
					nx = pool_next[list_pos[lid]];
					if (link_ok(nx)) begin
						list_pos[lid] = nx;
						res.data = pool_word[nx];
						res.valid = 1'b1;
						res.status = 1'b0;
					end else begin
						list_pos[lid] = pllm_pkg::NULL_LINK;
					end
				end
			end
			pllm_pkg::OP_SIZE: begin
				res.status = 1'b0;
			end
			pllm_pkg::OP_CLEAR: begin
				t = h;
				for (int i = 0; i < POOL && link_ok(t); i++) begin
					nx = pool_next[t];
					pool_next[t] = pllm_pkg::NULL_LINK;
					pool_free[t] = 1'b1;
					t = nx;
				end
				list_first[lid] = pllm_pkg::NULL_LINK;
				list_pos[lid] = pllm_pkg::NULL_LINK;
				list_len[lid] = '0;
				res.status = 1'b0;
			end
			default: begin
			end
		endcase
		res.count = list_len[lid];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// The beat is predicted at the edge that accepts it; s_tvalid stays high on return.
	task automatic send_beat(input logic [pllm_pkg::OPCODE_W-1:0] op,
			input logic [pllm_pkg::LIST_ID_W-1:0] lid,
			input logic [pllm_pkg::ITEM_W-1:0] word, output pllm_pkg::result_t pred);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, word, lid, op};
		do @(posedge clk); while (!s_tready);
		pred = predict_list_op(op, lid, word);
		list_op_replies.push_back(pred);
		beats_sent++;
	endtask

	task automatic test_empty_lists();
		pllm_pkg::result_t r;
		send_beat(pllm_pkg::OP_FIRST, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd0, 32'hFFFF_FFFF, r);
		send_beat(pllm_pkg::OP_SIZE, 2'd3, 32'h0, r);
		send_beat(pllm_pkg::OP_CLEAR, 2'd1, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd2, 32'h0, r);
	endtask

	task automatic test_append_and_walk();
		pllm_pkg::result_t r;
		send_beat(pllm_pkg::OP_APPEND, 2'd0, 32'h0000_0000, r);
		send_beat(pllm_pkg::OP_APPEND, 2'd0, 32'hFFFF_FFFF, r);
		send_beat(pllm_pkg::OP_APPEND, 2'd3, 32'h8000_0001, r);
		send_beat(pllm_pkg::OP_APPEND, 2'd0, 32'hA5A5_5A5A, r);
		send_beat(pllm_pkg::OP_FIRST, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_NEXT, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_SIZE, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_CLEAR, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_FIRST, 2'd0, 32'h0, r);
		send_beat(pllm_pkg::OP_FIRST, 2'd3, 32'h0, r);
		send_beat(pllm_pkg::OP_APPEND, 2'd1, 32'h0F0F_F0F0, r);
	endtask

	task automatic test_unknown_opcodes();
		pllm_pkg::result_t r;
		send_beat(3'd5, 2'd3, 32'h1234_5678, r);
		send_beat(3'd6, 2'd1, 32'hFFFF_FFFF, r);
		send_beat(3'd7, 2'd2, 32'h0, r);
		send_beat(3'd7, 2'd3, 32'h0, r);
	endtask

	task automatic test_pool_exhaustion();
		pllm_pkg::result_t r;
		for (int l = 0; l < LISTS; l++)
			send_beat(pllm_pkg::OP_CLEAR, pllm_pkg::LIST_ID_W'(l), $urandom, r);
		do
			send_beat(pllm_pkg::OP_APPEND,
				pllm_pkg::LIST_ID_W'($urandom_range(LISTS - 1)), $urandom, r);
		while (r.status == 1'b0);
		send_beat(pllm_pkg::OP_APPEND,
			pllm_pkg::LIST_ID_W'($urandom_range(LISTS - 1)), $urandom, r);
		send_beat(pllm_pkg::OP_FIRST, 2'd2, $urandom, r);
		for (int i = 0; i < POOL && r.valid; i++)
			send_beat(pllm_pkg::OP_NEXT, 2'd2, $urandom, r);
		send_beat(pllm_pkg::OP_CLEAR, 2'd2, $urandom, r);
		send_beat(pllm_pkg::OP_APPEND, 2'd0, $urandom, r);
	endtask

	task automatic test_backpressure();
		pllm_pkg::result_t r;
		int saved_tx;
		saved_tx = tx_idle_pct;
		tx_idle_pct = 0;
		stall_gen++;
		for (int i = 0; i < 40; i++)
			send_beat(($urandom_range(3) == 0) ? pllm_pkg::OP_SIZE : pllm_pkg::OP_APPEND,
				pllm_pkg::LIST_ID_W'($urandom_range(LISTS - 1)), $urandom, r);
		tx_idle_pct = saved_tx;
	endtask

	// Mostly build-and-walk sequences on one list, with bursts of arbitrary beats between.
	task automatic test_random_traffic(input int beats);
		pllm_pkg::result_t r;
		logic [pllm_pkg::LIST_ID_W-1:0] lid;
		int stop_at;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			lid = pllm_pkg::LIST_ID_W'($urandom_range(LISTS - 1));
			if ($urandom_range(9) < 6) begin
				repeat ($urandom_range(1, 7))
					send_beat(pllm_pkg::OP_APPEND, lid, $urandom, r);
				send_beat(pllm_pkg::OP_FIRST, lid, $urandom, r);
				for (int i = 0; i < POOL && r.valid; i++)
					send_beat(pllm_pkg::OP_NEXT, lid, $urandom, r);
				if ($urandom_range(1))
					send_beat(pllm_pkg::OP_NEXT, lid, $urandom, r);
				if ($urandom_range(2) == 0)
					send_beat(pllm_pkg::OP_CLEAR, lid, $urandom, r);
			end else begin
				repeat ($urandom_range(3, 10))
					send_beat(pllm_pkg::OPCODE_W'($urandom_range(7)),
						pllm_pkg::LIST_ID_W'($urandom_range(LISTS - 1)), $urandom, r);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_gen != stall_seen) begin
			stall_seen = stall_gen;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_reply
		pllm_pkg::result_t got;
		pllm_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[0];
			got.data = m_tdata[32:1];
			got.count = m_tdata[37:33];
			got.valid = m_tuser[0];
			if (list_op_replies.size() == 0) begin
				report_mismatch("result beat with no request outstanding");
			end else begin
				want = list_op_replies.pop_front();
				replies_checked++;
				if (want.valid)
					words_returned++;
				if (got.status !== want.status)
					report_mismatch($sformatf("status %b, wanted %b", got.status, want.status));
				if (got.data !== want.data)
					report_mismatch($sformatf("out_data %h, wanted %h", got.data, want.data));
				if (got.valid !== want.valid)
					report_mismatch($sformatf("data_valid %b, wanted %b", got.valid, want.valid));
				if (got.count !== want.count)
					report_mismatch($sformatf("list_count %0d, wanted %0d", got.count, want.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout with %0d results outstanding.", list_op_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < POOL; i++) begin
			pool_word[i] = '0;
			pool_next[i] = pllm_pkg::NULL_LINK;
			pool_free[i] = 1'b1;
		end
		for (int l = 0; l < LISTS; l++) begin
			list_first[l] = pllm_pkg::NULL_LINK;
			list_pos[l] = pllm_pkg::NULL_LINK;
			list_len[l] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 12;
		rx_idle_pct = 63;
		test_empty_lists();
		test_append_and_walk();
		test_unknown_opcodes();
		test_pool_exhaustion();
		test_random_traffic(110);
		test_backpressure();

		tx_idle_pct = 63;
		rx_idle_pct = 12;
		test_random_traffic(110);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(110);
		test_pool_exhaustion();

		s_tvalid <= 1'b0;
		while (list_op_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats and checked %0d results, %0d of them carrying a list word.",
			beats_sent, replies_checked, words_returned);
		$display("Appends refused on a full pool: %0d; mismatches: %0d.",
			pool_full_hits, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
